// File: hw/rtl/ldw_pkg.sv
// shared types, constants and helpers of the decimal number writer
package ldw_pkg;

    // display codes and character offsets
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW2_OFFSET  = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    // row selector codes
    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    // digits taken apart by the pipeline stages, the ones digit is what remains
    localparam int NUM_STAGES = 4;
    localparam int NUM_DIGITS = NUM_STAGES + 1;

    // item as it travels through the digit stages
    typedef struct packed {
        logic                         has_cmd;
        logic [7:0]                   cmd_byte;
        logic [15:0]                  rem;
        logic [NUM_STAGES-1:0][3:0]   digits;
    } ldw_item_t;

    // place value handled by each digit stage
    function automatic logic [16:0] place_value(input int idx);
        logic [16:0] pv;
        begin
            case (idx)
                0:       pv = 17'd10000;
                1:       pv = 17'd1000;
                2:       pv = 17'd100;
                default: pv = 17'd10;
            endcase
            return pv;
        end
    endfunction

endpackage

// File: hw/rtl/ldw_digit_stage.sv
// one pipeline stage that extracts one decimal digit by parallel compares
module ldw_digit_stage #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldw_pkg::ldw_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ldw_pkg::ldw_item_t out_item
);
    import ldw_pkg::*;

    localparam logic [16:0] PLACE = place_value(IDX);

    logic      valid_reg;
    ldw_item_t item_reg;
    ldw_item_t item_next;
    logic [3:0]  digit;
    logic [16:0] sub;

    // compare against every multiple of the place value, keep the highest hit
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, in_item.rem} >= 17'(k) * PLACE)
            begin
                digit = 4'(k);
                sub   = 17'(k) * PLACE;
            end
        end
        item_next             = in_item;
        item_next.rem         = 16'({1'b0, in_item.rem} - sub);
        item_next.digits[IDX] = digit;
    end

    // stage advances when empty or when the next stage takes its request
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hw/rtl/ldw_serializer.sv
// turns one converted item into an optional command byte and digit bytes, one per cycle while the output is not stalled
module ldw_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ldw_pkg::ldw_item_t in_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import ldw_pkg::*;

    // byte positions: command, then digits from the ten-thousands to the ones
    localparam logic [2:0] POS_CMD  = 3'd0;
    localparam logic [2:0] POS_ONES = 3'(NUM_DIGITS);

    logic                       item_v_reg;
    logic [7:0]                 cmd_byte_reg;
    logic [NUM_DIGITS-1:0][3:0] dig_reg;
    logic [2:0]                 pos_reg;
    logic [2:0]                 first_reg;
    logic                       out_v_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_data_reg;
    logic                       out_last_reg;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       load;
    logic [2:0] first_pos;
    logic [2:0] dig_idx;
    logic [7:0] cur_byte;
    logic       cur_data;

    // first significant digit of the incoming item, ones digit always shown
    always_comb
    begin
        first_pos = POS_ONES;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            if (in_item.digits[i] != 4'd0)
            begin
                first_pos = 3'(i + 1);
            end
        end
    end

    // byte at the current position
    assign dig_idx = pos_reg - 3'd1;
    always_comb
    begin
        if (pos_reg == POS_CMD)
        begin
            cur_byte = cmd_byte_reg;
            cur_data = 1'b0;
        end
        else
        begin
            cur_byte = ASCII_ZERO + {4'd0, dig_reg[dig_idx]};
            cur_data = 1'b1;
        end
    end

    assign out_free = !out_v_reg || m_tready;
    assign emit     = item_v_reg && out_free;
    assign is_last  = (pos_reg == POS_ONES);
    assign in_ready = !item_v_reg || (emit && is_last);
    assign load     = in_valid && in_ready;

    // item holding register and position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            pos_reg    <= POS_CMD;
            first_reg  <= POS_ONES;
        end
        else if (load)
        begin
            item_v_reg <= 1'b1;
            pos_reg    <= in_item.has_cmd ? POS_CMD : first_pos;
            first_reg  <= first_pos;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                item_v_reg <= 1'b0;
            end
            else if (pos_reg == POS_CMD)
            begin
                pos_reg <= first_reg;
            end
            else
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_byte_reg                  <= in_item.cmd_byte;
            dig_reg[NUM_STAGES-1:0]       <= in_item.digits;
            dig_reg[NUM_DIGITS-1]         <= in_item.rem[3:0];
        end
    end

    // output register parts the item holder from the downstream stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_data_reg <= cur_data;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/lcd_decimal_number_writer.sv
// top level of the decimal number writer for a two-line character display
//
// Each request carries a row, a start column and a 16-bit unsigned number. The block
// sends a set-address command byte (rows 1 and 2 only) followed by the number's decimal
// digits in ASCII, leading zeros blanked, zero shown as a single '0'; tlast marks the
// final byte. A request is converted by four digit-extraction pipeline stages and then
// serialized onto the single byte-wide result channel, 1 to 6 bytes per request. A new
// request is taken every cycle while the pipeline has room, and the first byte passes
// through the digit stages, the serializer's item register and its output register.
module lcd_decimal_number_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[1:0], column[6:2], number[22:7], zero[23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast
);
    import ldw_pkg::*;

    logic [1:0]  row;
    logic [4:0]  column;
    logic [15:0] number;
    ldw_item_t   entry;
    logic [7:0]  row_base;

    logic      [NUM_STAGES:0] st_valid;
    logic      [NUM_STAGES:0] st_ready;
    ldw_item_t [NUM_STAGES:0] st_item;

    assign row    = s_tdata[1:0];
    assign column = s_tdata[6:2];
    assign number = s_tdata[22:7];

    // address command byte and initial remainder
    always_comb
    begin
        row_base       = (row == ROW_SECOND) ? (CMD_SET_ADDR + ROW2_OFFSET) : CMD_SET_ADDR;
        entry          = '0;
        entry.has_cmd  = (row == ROW_FIRST) || (row == ROW_SECOND);
        entry.cmd_byte = row_base + {3'd0, column} - 8'd1;
        entry.rem      = number;
    end

    assign st_valid[0] = s_tvalid;
    assign st_item[0]  = entry;
    assign s_tready    = st_ready[0];

    // digit extraction pipeline
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        ldw_digit_stage #(
            .IDX (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_item   (st_item[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_item  (st_item[g+1])
        );
    end

    // byte serializer with output register
    ldw_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (st_valid[NUM_STAGES]),
        .in_ready (st_ready[NUM_STAGES]),
        .in_item  (st_item[NUM_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/ldw_checker.sv
// port-level checks of the decimal number writer, bound to the top level
module ldw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled output request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output request changed");

    // a command byte is never the final byte of an item
    a_cmd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tlast)
        else $error("command byte flagged last");

    // data bytes are ascii digits
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata >= 8'h30) && (m_tdata <= 8'h39))
        else $error("data byte is not a decimal digit");

    // a taken command byte is never followed directly by another command byte
    a_cmd_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> !m_tvalid || m_tuser)
        else $error("command byte not followed by a digit");

endmodule

bind lcd_decimal_number_writer ldw_checker u_ldw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
